/* src/cfb_pkg.sv */
// Shared types and constants for the command frame builder.
// No dependencies; every module of the block imports this package.
package cfb_pkg;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LIMIT = 2'd2;

    localparam logic [7:0] HEADER_FIRST_RST  = 8'd170;
    localparam logic [7:0] HEADER_SECOND_RST = 8'd85;
    localparam logic [7:0] PAYLOAD_LIMIT_RST = 8'd254;

    // Largest payload length whose length byte (length + 1) still fits in 8 bits
    localparam logic [7:0] LEN_CAP   = 8'd254;
    localparam logic [7:0] LEN_EXTRA = 8'd1;

    // Input action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_BYTE  = 1'b1;

    // Default depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // Beat index inside one command: a start has up to five beats
    localparam int unsigned STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_HDR1 = 3'd0;
    localparam logic [STEP_W-1:0] STEP_HDR2 = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LEN  = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CMD  = 3'd3;
    localparam logic [STEP_W-1:0] STEP_SUM  = 3'd4;

    typedef enum logic [1:0] {
        K_ERROR,
        K_START,
        K_DATA
    } t_kind;

    // Classified command handed from front to back
    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;     // command code on a start, payload byte on data
        logic [7:0] len_byte;  // payload length + 1, starts only
        logic [7:0] sum;       // checksum, valid when with_sum is set
        logic       with_sum;  // command closes the frame
    } t_cmd;

endpackage

/* src/cfb_item_if.sv */
// Input channel of the command frame builder: one start or payload item per beat.
// Depends on nothing but the clock domain of the user.
interface cfb_item_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] cmd;
    logic [7:0] body_len;
    logic [7:0] data;

    modport source (output valid, action, cmd, body_len, data, input ready);
    modport sink   (input valid, action, cmd, body_len, data, output ready);
endinterface

/* src/cfb_beat_if.sv */
// Output channel of the command frame builder: one frame byte per beat.
// Depends on nothing but the clock domain of the user.
interface cfb_beat_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    logic       error;

    modport source (output valid, out_byte, last, error, input ready);
    modport sink   (input valid, out_byte, last, error, output ready);
endinterface

/* src/cfb_front.sv */
// Front part: accepts items, tracks the open frame and builds one command per item.
// Depends on cfb_pkg and cfb_item_if.
module cfb_front
    import cfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    cfb_item_if.sink    i_item,
    input  logic        i_queue_ready,
    input  logic [7:0]  i_payload_limit,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic       r_frame_open;
    logic [7:0] r_bytes_left;
    logic [7:0] r_running_sum;
    logic       n_frame_open;
    logic [7:0] n_bytes_left;
    logic [7:0] n_running_sum;

    logic [7:0] w_limit;
    logic [7:0] w_len_byte;
    logic [7:0] w_start_sum;
    logic [7:0] w_data_sum;
    logic [7:0] w_left_dec;

    assign i_item.ready = i_queue_ready;
    assign o_push       = i_item.valid && i_queue_ready;

    // Clamp the limit so the length byte never wraps
    assign w_limit     = (i_payload_limit > LEN_CAP) ? LEN_CAP : i_payload_limit;
    assign w_len_byte  = i_item.body_len + LEN_EXTRA;
    assign w_start_sum = w_len_byte + i_item.cmd;
    assign w_data_sum  = r_running_sum + i_item.data;
    assign w_left_dec  = r_bytes_left - 8'd1;

    // Classify the item and work out the frame state it leaves
    always_comb begin
        n_frame_open   = r_frame_open;
        n_bytes_left   = r_bytes_left;
        n_running_sum  = r_running_sum;
        o_cmd.kind     = K_ERROR;
        o_cmd.value    = i_item.cmd;
        o_cmd.len_byte = w_len_byte;
        o_cmd.sum      = w_start_sum;
        o_cmd.with_sum = 1'b0;
        if (i_item.action == ACT_START) begin
            if (!r_frame_open && (i_item.body_len <= w_limit)) begin
                o_cmd.kind = K_START;
                if (i_item.body_len == 8'd0) begin
                    o_cmd.with_sum = 1'b1;
                    n_running_sum  = 8'd0;
                end else begin
                    n_frame_open  = 1'b1;
                    n_bytes_left  = i_item.body_len;
                    n_running_sum = w_start_sum;
                end
            end
        end else if (r_frame_open) begin
            o_cmd.kind  = K_DATA;
            o_cmd.value = i_item.data;
            o_cmd.sum   = w_data_sum;
            if (w_left_dec == 8'd0) begin
                o_cmd.with_sum = 1'b1;
                n_frame_open   = 1'b0;
                n_bytes_left   = 8'd0;
                n_running_sum  = 8'd0;
            end else begin
                n_bytes_left  = w_left_dec;
                n_running_sum = w_data_sum;
            end
        end
    end

    // Advance the frame state on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open  <= 1'b0;
            r_bytes_left  <= 8'd0;
            r_running_sum <= 8'd0;
        end else if (o_push) begin
            r_frame_open  <= n_frame_open;
            r_bytes_left  <= n_bytes_left;
            r_running_sum <= n_running_sum;
        end
    end

endmodule

/* src/cfb_queue.sv */
// Short command queue between front and back; either side may stall on its own.
// Depends on cfb_pkg.
module cfb_queue
    import cfb_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_ready,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_count != CNT_FULL);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

/* src/cfb_back.sv */
// Back part: expands each command into its frame bytes, one beat per cycle while the sink
// is ready, through a registered output stage. Depends on cfb_pkg and cfb_beat_if.
module cfb_back
    import cfb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_head_valid,
    input  t_cmd        i_head,
    output logic        o_pop,
    input  logic [7:0]  i_header_first,
    input  logic [7:0]  i_header_second,
    cfb_beat_if.source  o_beat
);

    t_cmd              r_cur;
    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_last;
    logic              r_out_error;

    logic [7:0] w_byte;
    logic       w_last;
    logic       w_error;
    logic       w_final;
    logic       w_load;

    assign o_beat.valid    = r_out_valid;
    assign o_beat.out_byte = r_out_byte;
    assign o_beat.last     = r_out_last;
    assign o_beat.error    = r_out_error;

    // Output stage takes a beat when empty or being drained
    assign w_load = r_busy && (!r_out_valid || o_beat.ready);
    assign o_pop  = i_head_valid && (!r_busy || (w_load && w_final));

    // Select the byte for the current step of the command
    always_comb begin
        w_byte  = 8'd0;
        w_last  = 1'b0;
        w_error = 1'b0;
        w_final = 1'b0;
        unique case (r_cur.kind)
            K_START: begin
                case (r_step)
                    STEP_HDR1: w_byte = i_header_first;
                    STEP_HDR2: w_byte = i_header_second;
                    STEP_LEN:  w_byte = r_cur.len_byte;
                    STEP_CMD: begin
                        w_byte  = r_cur.value;
                        w_final = !r_cur.with_sum;
                    end
                    default: begin
                        w_byte  = r_cur.sum;
                        w_last  = 1'b1;
                        w_final = 1'b1;
                    end
                endcase
            end
            K_DATA: begin
                if (r_step == STEP_HDR1) begin
                    w_byte  = r_cur.value;
                    w_final = !r_cur.with_sum;
                end else begin
                    w_byte  = r_cur.sum;
                    w_last  = 1'b1;
                    w_final = 1'b1;
                end
            end
            default: begin
                w_last  = 1'b1;
                w_error = 1'b1;
                w_final = 1'b1;
            end
        endcase
    end

    // Hold the current command and advance through its beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= STEP_HDR1;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_step <= STEP_HDR1;
        end else if (w_load) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_beat.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_byte  <= w_byte;
            r_out_last  <= w_last;
            r_out_error <= w_error;
        end
    end

endmodule

/* src/command_frame_builder.sv */
// Top level of the command frame builder: configuration registers, front, queue, back.
// Depends on cfb_pkg, cfb_item_if, cfb_beat_if, cfb_front, cfb_queue, cfb_back.
//
//   channel   direction  beat carries
//   i_item    in         action, cmd, body_len, data
//   o_beat    out        out_byte, last, error
//   i_cfg_*   in         write enable, register index, 8-bit data
//
// The front takes one item per cycle whenever the queue has room. The back sends
// one byte per cycle while the sink is ready: a start gives 4 or 5 beats, a
// payload byte 1 or 2, a rejected item 1, so the sustained item rate follows the
// output beat count. An item's bytes pass the queue entry, command and output registers.
// Synchronous active-low reset clears frame state, queue and output valid.
// Either side may stall at any time; the queue absorbs the difference.
module command_frame_builder
    import cfb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cfb_item_if.sink             i_item,
    cfb_beat_if.source           o_beat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data
);

    logic [7:0] r_header_first;
    logic [7:0] r_header_second;
    logic [7:0] r_payload_limit;

    logic w_push;
    t_cmd w_cmd;
    logic w_queue_ready;
    logic w_pop;
    logic w_head_valid;
    t_cmd w_head;

    // Configuration registers; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= HEADER_FIRST_RST;
            r_header_second <= HEADER_SECOND_RST;
            r_payload_limit <= PAYLOAD_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                REG_HEADER_SECOND: r_header_second <= i_cfg_data;
                REG_PAYLOAD_LIMIT: r_payload_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cfb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_item          (i_item),
        .i_queue_ready   (w_queue_ready),
        .i_payload_limit (r_payload_limit),
        .o_push          (w_push),
        .o_cmd           (w_cmd)
    );

    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .o_ready (w_queue_ready),
        .i_pop   (w_pop),
        .o_valid (w_head_valid),
        .o_head  (w_head)
    );

    cfb_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (w_head_valid),
        .i_head          (w_head),
        .o_pop           (w_pop),
        .i_header_first  (r_header_first),
        .i_header_second (r_header_second),
        .o_beat          (o_beat)
    );

    // An error beat is always a lone zero byte marked last
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_beat.valid && o_beat.error |-> o_beat.last && (o_beat.out_byte == 8'd0))
        else $error("error beat not zero or not last");

    // The back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head_valid)
        else $error("pop from empty command queue");

    // A push never lands on a full queue
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_queue_ready)
        else $error("push into full command queue");

    // Output is empty right after reset
    a_out_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_beat.valid)
        else $error("output valid after reset");

endmodule

/* sim/cfb_frame_checker.sv */
// Frame checker for the command frame builder: watches the item, beat and config ports.
// Predicts every output beat per accepted item and compares in order.
// Depends on cfb_pkg, cfb_item_if and cfb_beat_if.
module cfb_frame_checker
    import cfb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cfb_item_if                  i_item,
    cfb_beat_if                  i_beat,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    output int                   o_fail_count,
    output int                   o_beats_due
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       error;
    } t_frame_beat;

    // Shadow copy of the configuration registers
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] len_limit;

    // Shadow copy of the frame state
    logic       in_frame;
    logic [7:0] payload_left;
    logic [7:0] frame_sum;

    t_frame_beat frame_beats_due[$];
    t_frame_beat got_beat;
    t_frame_beat want_beat;
    int          mismatches;

    initial begin
        o_fail_count = 0;
        o_beats_due  = 0;
        mismatches   = 0;
    end

    task automatic queue_beat(input logic [7:0] b, input logic l, input logic e);
        t_frame_beat fb;
        fb.byte_val = b;
        fb.last     = l;
        fb.error    = e;
        frame_beats_due.push_back(fb);
    endtask

    // Work out the beats one accepted item causes and advance the frame state
    task automatic predict_frame_beats(input logic act, input logic [7:0] cmd,
                                       input logic [7:0] plen, input logic [7:0] data);
        logic [7:0] eff_limit;
        logic [7:0] len_byte;
        eff_limit = (len_limit > LEN_CAP) ? LEN_CAP : len_limit;
        if (act == ACT_START) begin
            if (in_frame || plen > eff_limit) begin
                queue_beat(8'd0, 1'b1, 1'b1);
            end else begin
                len_byte = plen + LEN_EXTRA;
                queue_beat(sync_first, 1'b0, 1'b0);
                queue_beat(sync_second, 1'b0, 1'b0);
                queue_beat(len_byte, 1'b0, 1'b0);
                queue_beat(cmd, 1'b0, 1'b0);
                frame_sum = len_byte + cmd;
                if (plen == 8'd0) begin
                    queue_beat(frame_sum, 1'b1, 1'b0);
                    frame_sum = 8'd0;
                end else begin
                    in_frame     = 1'b1;
                    payload_left = plen;
                end
            end
        end else if (!in_frame) begin
            queue_beat(8'd0, 1'b1, 1'b1);
        end else begin
            queue_beat(data, 1'b0, 1'b0);
            frame_sum    = frame_sum + data;
            payload_left = payload_left - 8'd1;
            if (payload_left == 8'd0) begin
                queue_beat(frame_sum, 1'b1, 1'b0);
                in_frame  = 1'b0;
                frame_sum = 8'd0;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sync_first   = HEADER_FIRST_RST;
            sync_second  = HEADER_SECOND_RST;
            len_limit    = PAYLOAD_LIMIT_RST;
            in_frame     = 1'b0;
            payload_left = 8'd0;
            frame_sum    = 8'd0;
            frame_beats_due.delete();
        end else begin
            // Predict from the item beat
            if (i_item.valid === 1'b1 && i_item.ready === 1'b1) begin
                predict_frame_beats(i_item.action, i_item.cmd, i_item.body_len,
                                    i_item.data);
            end

            // Compare the output beat against the oldest prediction
            if (i_beat.valid === 1'b1 && i_beat.ready === 1'b1) begin
                got_beat.byte_val = i_beat.out_byte;
                got_beat.last     = i_beat.last;
                got_beat.error    = i_beat.error;
                if (frame_beats_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("%0t: unexpected beat: byte %02h last %0b error %0b",
                                 $time, got_beat.byte_val, got_beat.last, got_beat.error);
                    end
                end else begin
                    want_beat = frame_beats_due.pop_front();
                    if (got_beat.byte_val !== want_beat.byte_val ||
                        got_beat.last !== want_beat.last ||
                        got_beat.error !== want_beat.error) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("%0t: beat mismatch: exp %02h/%0b/%0b got %02h/%0b/%0b",
                                     $time, want_beat.byte_val, want_beat.last,
                                     want_beat.error, got_beat.byte_val, got_beat.last,
                                     got_beat.error);
                        end
                    end
                end
            end

            // Apply a register write after this edge's item
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_index)
                    REG_HEADER_FIRST:  sync_first  = i_cfg_data;
                    REG_HEADER_SECOND: sync_second = i_cfg_data;
                    REG_PAYLOAD_LIMIT: len_limit   = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_beats_due  <= frame_beats_due.size();
        o_fail_count <= mismatches;
    end

endmodule

/* sim/tb.sv */
// Testbench top for the command frame builder: clock, reset, stimulus and verdict.
// Depends on cfb_pkg, cfb_item_if, cfb_beat_if, command_frame_builder, cfb_frame_checker.
module tb
    import cfb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int PHASE_ITEMS = 46;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [7:0]           cfg_data;

    bit         src_gaps    = 1'b1;
    bit         sink_stalls = 1'b1;
    int         fail_count;
    int         beats_due;
    int         open_left;
    logic [7:0] gen_limit;

    cfb_item_if item_ch ();
    cfb_beat_if beat_ch ();

    command_frame_builder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_item     (item_ch),
        .o_beat     (beat_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    cfb_frame_checker u_frame_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_item      (item_ch),
        .i_beat      (beat_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_beats_due (beats_due)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on run time
    initial begin
        #2_000_000;
        $display("** command_frame_builder: FAILED **");
        $finish;
    end

    // Drive output ready in random bursts
    initial begin
        beat_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            beat_ch.ready <= !(sink_stalls && $urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    end

    // Present one item and hold it until accepted
    task automatic send_item(input logic act, input logic [7:0] c, input logic [7:0] pl,
                             input logic [7:0] d);
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_ch.valid    <= 1'b1;
        item_ch.action   <= act;
        item_ch.cmd      <= c;
        item_ch.body_len <= pl;
        item_ch.data     <= d;
        do @(posedge clk); while (item_ch.ready !== 1'b1);
    endtask

    task automatic send_start(input logic [7:0] c, input logic [7:0] pl);
        send_item(ACT_START, c, pl, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_byte(input logic [7:0] d);
        send_item(ACT_BYTE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), d);
    endtask

    // Hold the sender until every predicted beat has left the block
    task automatic drain();
        item_ch.valid <= 1'b0;
        do @(posedge clk); while (beats_due != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_PAYLOAD_LIMIT) begin
            gen_limit = (val > LEN_CAP) ? LEN_CAP : val;
        end
    endtask

    task automatic finish_frame();
        while (open_left > 0) begin
            send_byte(8'($urandom_range(0, 255)));
            open_left--;
        end
    endtask

    // One random item: mostly well-formed frames, some rejected items mixed in
    task automatic random_item();
        int         pick;
        int         cap;
        logic [7:0] plen;
        pick = $urandom_range(0, 99);
        if (open_left > 0) begin
            if (pick < 8) begin
                send_start(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
                send_byte(8'($urandom_range(0, 255)));
                open_left--;
            end
        end else if (pick < 72) begin
            cap  = (pick < 66) ? 6 : 40;
            cap  = (gen_limit < cap) ? gen_limit : cap;
            plen = 8'($urandom_range(0, cap));
            send_start(8'($urandom_range(0, 255)), plen);
            open_left = plen;
        end else if (pick < 86) begin
            send_start(8'($urandom_range(0, 255)), 8'($urandom_range(gen_limit + 1, 255)));
        end else begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        logic [7:0] phase_limit [4];
        rst_n            <= 1'b0;
        item_ch.valid    <= 1'b0;
        item_ch.action   <= ACT_START;
        item_ch.cmd      <= 8'd0;
        item_ch.body_len <= 8'd0;
        item_ch.data     <= 8'd0;
        cfg_we           <= 1'b0;
        cfg_index        <= REG_HEADER_FIRST;
        cfg_data         <= 8'd0;
        gen_limit         = PAYLOAD_LIMIT_RST;
        open_left         = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset configuration: stray byte, empty payload, too long, nested start, wrap
        send_byte(8'hFF);
        send_start(8'h00, 8'd0);
        send_start(8'hFF, 8'hFF);
        send_start(8'h5A, 8'd2);
        send_byte(8'hFF);
        send_start(8'h11, 8'd0);
        send_byte(8'h00);
        send_start(8'hFF, 8'd1);
        send_byte(8'hFF);
        drain();

        // Extreme sync bytes and a zero payload limit
        write_reg(REG_HEADER_FIRST, 8'h00);
        write_reg(REG_HEADER_SECOND, 8'hFF);
        write_reg(REG_PAYLOAD_LIMIT, 8'h00);
        send_start(8'h80, 8'd0);
        send_start(8'h01, 8'd1);
        send_byte(8'h7F);
        drain();

        // Limit of 255 acts as 254; unused index is dropped; a longer frame
        write_reg(REG_PAYLOAD_LIMIT, 8'hFF);
        write_reg(REG_UNUSED, 8'hFF);
        send_start(8'hC3, 8'hFF);
        send_start(8'h3C, 8'd20);
        open_left = 20;
        finish_frame();
        drain();

        // Random phases with changing configuration and idling
        phase_limit[0] = 8'($urandom_range(0, 255));
        phase_limit[1] = 8'hFF;
        phase_limit[2] = 8'($urandom_range(0, 20));
        phase_limit[3] = LEN_CAP;
        for (int phase = 0; phase < 4; phase++) begin
            src_gaps    = (phase < 2);
            sink_stalls = (phase == 0 || phase == 2);
            write_reg(REG_HEADER_FIRST, 8'($urandom_range(0, 255)));
            write_reg(REG_HEADER_SECOND, 8'($urandom_range(0, 255)));
            write_reg(REG_PAYLOAD_LIMIT, phase_limit[phase]);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
            end
            finish_frame();
            drain();
        end

        if (fail_count == 0) begin
            $display("** command_frame_builder: PASSED **");
        end else begin
            $display("** command_frame_builder: FAILED **");
        end
        $finish;
    end

endmodule
